[hdl/vsts_pkg.sv]
// Shared types and constants of the rotated trilinear volume sampler.
`default_nettype none
package vsts_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int SIDE_W      = 6;
  localparam int IDX_W       = 5;
  localparam int VOXEL_COUNT = 32768;
  localparam int ADDR_W      = 15;
  localparam int VAL_W       = 32;
  localparam int COORD_W     = 16;
  localparam int QUAT_W      = 16;
  localparam int TERM_W      = 18;
  localparam int STEP_W      = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_J = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_K = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_Z = 3'd6;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [STEP_W-1:0] REBUILD_LAST = 6'd10;
  localparam logic [STEP_W-1:0] ROT_LAST     = 6'd8;
  localparam logic [STEP_W-1:0] CORNER_LAST  = 6'd7;
  localparam logic [STEP_W-1:0] DIV_LAST     = 6'd31;

  localparam logic [VAL_W-1:0] NO_DATA_VALUE = 32'hFFFF_0000;
  localparam logic [VAL_W-1:0] SAT_VALUE     = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_REBUILD,
    ST_IDLE,
    ST_ROTATE,
    ST_AXIS,
    ST_CORNER_RD,
    ST_CORNER_MUL,
    ST_CORNER_WT,
    ST_CORNER_ACC,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_OUT
  } vsts_state_t;

  typedef struct packed {
    logic              accept_write;
    logic              accept_sample;
    logic              cfg_we;
    logic              reb_mul;
    logic              reb_fin;
    logic              rot_mac;
    logic              axis_calc;
    logic              corner_rd;
    logic              corner_mul;
    logic              corner_wt;
    logic              corner_acc;
    logic              div_init;
    logic              div_step;
    logic [STEP_W-1:0] step;
  } vsts_cmd_t;

  typedef struct packed {
    logic bad;
    logic wsum_zero;
    logic corner_active;
  } vsts_stat_t;

endpackage
`default_nettype wire

[hdl/volume_slice_trilinear_sampler.sv]
// Top level of the rotated trilinear volume sampler.
`default_nettype none
// Usage:
// An item is taken at a clock edge with start high and busy low. With mode 0
// it writes voxel_value at voxel_index in the same transfer and the block stays
// free for the next item in the following cycle; a write returns no result.
// With mode 1 the coordinate is rotated by the quaternion matrix, sampled
// trilinearly and the result appears on sample_value, no_data and slice_end
// for exactly one cycle with done high. The sample sequencer runs the rotation
// multiply-accumulates, the axis step and then the corner walk over the single
// volume memory port, which reads, multiplies, weights and accumulates each
// corner that carries weight and skips the others, then the restoring divider.
// A sample out of range skips the corner walk and the divider, and one in which
// no corner carries weight skips the divider; busy stays high until done.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and
// cfg_data. A quaternion write rebuilds the matrix, during which busy is high.
// After reset the registers take their defaults and the same rebuild runs
// before the first item is accepted. The volume memory has no reset and must
// be written before it is read. The receiver of done cannot stall the block.
module volume_slice_trilinear_sampler
  import vsts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      mode,
  input  wire logic [ADDR_W-1:0]         voxel_index,
  input  wire logic signed [VAL_W-1:0]   voxel_value,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  input  wire logic                      last_of_slice,
  output logic                           done,
  output logic signed [VAL_W-1:0]        sample_value,
  output logic                           no_data,
  output logic                           slice_end,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  vsts_cmd_t  cmd;
  vsts_stat_t stat;

  vsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .stat     (stat),
    .busy     (busy),
    .done     (done),
    .cfg_ready(cfg_ready),
    .cmd      (cmd)
  );

  vsts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .voxel_index  (voxel_index),
    .voxel_value  (voxel_value),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .last_of_slice(last_of_slice),
    .sample_value (sample_value),
    .no_data      (no_data),
    .slice_end    (slice_end)
  );

endmodule
`default_nettype wire

[hdl/vsts_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module vsts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[hdl/vsts_ctrl.sv]
// Sequencer of the sampler: rebuild, rotation, corner walk and division.
`default_nettype none
module vsts_ctrl
  import vsts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 mode,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire vsts_stat_t           stat,
  output logic                      busy,
  output logic                      done,
  output logic                      cfg_ready,
  output vsts_cmd_t                 cmd
);

  vsts_state_t       state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              cfg_xfer, quat_write;

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_OUT);
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign quat_write = (cfg_index == REG_QUAT_W) || (cfg_index == REG_QUAT_I) ||
                      (cfg_index == REG_QUAT_J) || (cfg_index == REG_QUAT_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_REBUILD;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    cmd.cfg_we = cfg_xfer;
    case (state)
      ST_REBUILD: begin
        if (step == REBUILD_LAST) begin
          cmd.reb_fin = 1'b1;
          state_next  = ST_IDLE;
          step_next   = '0;
        end else begin
          cmd.reb_mul = 1'b1;
          step_next   = step + 6'd1;
        end
      end
      ST_IDLE: begin
        if (start && (mode == MODE_SAMPLE)) begin
          cmd.accept_sample = 1'b1;
          state_next        = ST_ROTATE;
          step_next         = '0;
        end else if (start) begin
          cmd.accept_write = 1'b1;
        end else if (cfg_xfer && quat_write) begin
          state_next = ST_REBUILD;
          step_next  = '0;
        end
      end
      ST_ROTATE: begin
        cmd.rot_mac = 1'b1;
        if (step == ROT_LAST) begin
          state_next = ST_AXIS;
          step_next  = '0;
        end else begin
          step_next = step + 6'd1;
        end
      end
      ST_AXIS: begin
        cmd.axis_calc = 1'b1;
        state_next    = ST_CORNER_RD;
        step_next     = '0;
      end
      ST_CORNER_RD: begin
        if (stat.bad) begin
          state_next = ST_DIV_INIT;
        end else if (stat.corner_active) begin
          cmd.corner_rd = 1'b1;
          state_next    = ST_CORNER_MUL;
        end else if (step == CORNER_LAST) begin
          state_next = ST_DIV_INIT;
        end else begin
          step_next = step + 6'd1;
        end
      end
      ST_CORNER_MUL: begin
        cmd.corner_mul = 1'b1;
        state_next     = ST_CORNER_WT;
      end
      ST_CORNER_WT: begin
        cmd.corner_wt = 1'b1;
        state_next    = ST_CORNER_ACC;
      end
      ST_CORNER_ACC: begin
        cmd.corner_acc = 1'b1;
        if (step == CORNER_LAST) begin
          state_next = ST_DIV_INIT;
        end else begin
          state_next = ST_CORNER_RD;
          step_next  = step + 6'd1;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        if (stat.bad || stat.wsum_zero) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          state_next = ST_OUT;
        end else begin
          step_next = step + 6'd1;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("result strobe not followed by idle");
  a_sample_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_SAMPLE)) |=> busy)
    else $error("accepted sample did not start work");
  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_WRITE)) |=> !busy)
    else $error("voxel write made the block busy");
  a_quat_rebuilds: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && quat_write) |=> (busy && !done))
    else $error("quaternion write did not rebuild the matrix");
`endif

endmodule
`default_nettype wire

[hdl/vsts_dp.sv]
// Datapath: registers, rotation matrix, axis weights, corner walk and divider.
`default_nettype none
module vsts_dp
  import vsts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire vsts_cmd_t             cmd,
  output vsts_stat_t                 stat,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ADDR_W-1:0]     voxel_index,
  input  wire logic signed [VAL_W-1:0]   voxel_value,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  input  wire logic                  last_of_slice,
  output logic signed [VAL_W-1:0]    sample_value,
  output logic                       no_data,
  output logic                       slice_end
);

  typedef struct packed {
    logic             bad;
    logic [IDX_W-1:0] low;
    logic [16:0]      wl;
    logic [16:0]      wh;
  } axis_t;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
    if (s < 6'd2) return 6'd2;
    if (s > 6'(MAX_SIDE)) return 6'(MAX_SIDE);
    return s;
  endfunction

  function automatic logic signed [TERM_W-1:0] term_of(input logic signed [35:0] x);
    logic signed [35:0] r;
    r = (x + 36'sd8192) >>> 14;
    if (r > 36'sd131071) return 18'h1FFFF;
    if (r < -36'sd131072) return 18'h20000;
    return r[TERM_W-1:0];
  endfunction

  function automatic axis_t axis_of(input logic signed [36:0] acc,
                                    input logic [SIDE_W-1:0] side);
    logic signed [36:0] off, p, ce, low, lim, wl;
    axis_t r;
    off   = $signed({10'd0, side - 6'd1, 21'd0});
    p     = (acc + off + 37'sd32) >>> 6;
    ce    = (p + 37'sd65535) >>> 16;
    low   = ce - 37'sd1;
    lim   = $signed({31'd0, side}) - 37'sd1;
    wl    = (ce <<< 16) - p;
    r.bad = (low < -37'sd1) || (low > lim);
    r.low = low[IDX_W-1:0];
    r.wl  = wl[16:0];
    r.wh  = 17'd65536 - wl[16:0];
    if (low == -37'sd1) begin
      r.wl = '0;
    end else if (low == lim) begin
      r.wh = '0;
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [QUAT_W-1:0] quat_w, quat_i, quat_j, quat_k;
  logic [SIDE_W-1:0]        side_x, side_y, side_z;
  logic [SIDE_W-1:0]        sx_e, sy_e, sz_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= 16'sd16384;
      quat_i <= '0;
      quat_j <= '0;
      quat_k <= '0;
      side_x <= 6'd32;
      side_y <= 6'd32;
      side_z <= 6'd32;
    end else if (cmd.cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: quat_w <= cfg_data;
        REG_QUAT_I: quat_i <= cfg_data;
        REG_QUAT_J: quat_j <= cfg_data;
        REG_QUAT_K: quat_k <= cfg_data;
        REG_SIDE_X: side_x <= cfg_data[SIDE_W-1:0];
        REG_SIDE_Y: side_y <= cfg_data[SIDE_W-1:0];
        REG_SIDE_Z: side_z <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sx_e = eff_side(side_x);
  assign sy_e = eff_side(side_y);
  assign sz_e = eff_side(side_z);

  // Matrix rebuild: ten quaternion products, one per cycle, then all terms.
  logic signed [QUAT_W-1:0]   qa, qb;
  logic signed [31:0]         reb_prod;
  logic signed [31:0]         prod_q [10];
  logic signed [35:0]         ww, ii, jj, kk, ij, wk, ik, wj, jk, wi;
  logic signed [TERM_W-1:0]   terms [9];

  always_comb begin
    case (cmd.step[3:0])
      4'd0: begin qa = quat_w; qb = quat_w; end
      4'd1: begin qa = quat_i; qb = quat_i; end
      4'd2: begin qa = quat_j; qb = quat_j; end
      4'd3: begin qa = quat_k; qb = quat_k; end
      4'd4: begin qa = quat_i; qb = quat_j; end
      4'd5: begin qa = quat_w; qb = quat_k; end
      4'd6: begin qa = quat_i; qb = quat_k; end
      4'd7: begin qa = quat_w; qb = quat_j; end
      4'd8: begin qa = quat_j; qb = quat_k; end
      default: begin qa = quat_w; qb = quat_i; end
    endcase
  end

  assign reb_prod = qa * qb;
  assign ww = 36'(prod_q[0]);
  assign ii = 36'(prod_q[1]);
  assign jj = 36'(prod_q[2]);
  assign kk = 36'(prod_q[3]);
  assign ij = 36'(prod_q[4]);
  assign wk = 36'(prod_q[5]);
  assign ik = 36'(prod_q[6]);
  assign wj = 36'(prod_q[7]);
  assign jk = 36'(prod_q[8]);
  assign wi = 36'(prod_q[9]);

  always_ff @(posedge clk) begin
    if (cmd.reb_mul) begin
      prod_q[cmd.step[3:0]] <= reb_prod;
    end
    if (cmd.reb_fin) begin
      terms[0] <= term_of(ww + ii - jj - kk);
      terms[1] <= term_of((ij - wk) <<< 1);
      terms[2] <= term_of((ik + wj) <<< 1);
      terms[3] <= term_of((ij + wk) <<< 1);
      terms[4] <= term_of(ww - ii + jj - kk);
      terms[5] <= term_of((jk - wi) <<< 1);
      terms[6] <= term_of((ik - wj) <<< 1);
      terms[7] <= term_of((jk + wi) <<< 1);
      terms[8] <= term_of(ww - ii - jj + kk);
    end
  end

  // Sample capture and rotation multiply-accumulate.
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q, coord_sel;
  logic                      last_q;
  logic [10:0]               sysz_q;
  logic [1:0]                ax;
  logic signed [TERM_W-1:0]  term_sel;
  logic signed [33:0]        rot_prod;
  logic signed [36:0]        acc [3];

  always_comb begin
    case (cmd.step[3:0])
      4'd0: begin ax = 2'd0; coord_sel = cx_q; end
      4'd1: begin ax = 2'd0; coord_sel = cy_q; end
      4'd2: begin ax = 2'd0; coord_sel = cz_q; end
      4'd3: begin ax = 2'd1; coord_sel = cx_q; end
      4'd4: begin ax = 2'd1; coord_sel = cy_q; end
      4'd5: begin ax = 2'd1; coord_sel = cz_q; end
      4'd6: begin ax = 2'd2; coord_sel = cx_q; end
      4'd7: begin ax = 2'd2; coord_sel = cy_q; end
      default: begin ax = 2'd2; coord_sel = cz_q; end
    endcase
  end

  assign term_sel = (cmd.step[3:0] <= 4'd8) ? terms[cmd.step[3:0]] : '0;
  assign rot_prod = term_sel * coord_sel;

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      cx_q   <= coord_x;
      cy_q   <= coord_y;
      cz_q   <= coord_z;
      last_q <= last_of_slice;
      sysz_q <= 11'(sy_e * sz_e);
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end else if (cmd.rot_mac) begin
      acc[ax] <= acc[ax] + 37'(rot_prod);
    end
  end

  // Per-axis corner and weights.
  axis_t            ax_x, ax_y, ax_z;
  logic             bad_q;
  logic [IDX_W-1:0] low_q [3];
  logic [16:0]      wl_q [3];
  logic [16:0]      wh_q [3];

  assign ax_x = axis_of(acc[0], sx_e);
  assign ax_y = axis_of(acc[1], sy_e);
  assign ax_z = axis_of(acc[2], sz_e);

  always_ff @(posedge clk) begin
    if (cmd.axis_calc) begin
      bad_q    <= ax_x.bad || ax_y.bad || ax_z.bad;
      low_q[0] <= ax_x.low;
      low_q[1] <= ax_y.low;
      low_q[2] <= ax_z.low;
      wl_q[0]  <= ax_x.wl;
      wl_q[1]  <= ax_y.wl;
      wl_q[2]  <= ax_z.wl;
      wh_q[0]  <= ax_x.wh;
      wh_q[1]  <= ax_y.wh;
      wh_q[2]  <= ax_z.wh;
    end
  end

  // Corner walk: corner bits are {dx, dy, dz}.
  logic [2:0]        corner;
  logic [16:0]       wx_sel, wy_sel, wz_sel;
  logic [IDX_W-1:0]  ix, iy, iz;
  logic [ADDR_W-1:0] corner_addr, ram_addr;
  logic [VAL_W-1:0]  rdata, raw_q;
  logic [33:0]       wxy_q;
  logic [50:0]       wprod_q, wround;
  logic [24:0]       w_q;
  logic [27:0]       wsum_q;
  logic [59:0]       vsum_q, num;

  assign corner = cmd.step[2:0];
  assign wx_sel = corner[2] ? wh_q[0] : wl_q[0];
  assign wy_sel = corner[1] ? wh_q[1] : wl_q[1];
  assign wz_sel = corner[0] ? wh_q[2] : wl_q[2];
  assign ix = low_q[0] + IDX_W'(corner[2]);
  assign iy = low_q[1] + IDX_W'(corner[1]);
  assign iz = low_q[2] + IDX_W'(corner[0]);
  assign corner_addr = ADDR_W'(ix * sysz_q) + ADDR_W'(iy * sz_e) + ADDR_W'(iz);
  assign ram_addr = cmd.accept_write ? voxel_index : corner_addr;
  assign wround = wprod_q + 51'd8388608;

  vsts_ram #(
    .WIDTH(VAL_W),
    .DEPTH(VOXEL_COUNT)
  ) u_volume (
    .clk  (clk),
    .we   (cmd.accept_write),
    .addr (ram_addr),
    .wdata(voxel_value),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.corner_rd) begin
      wxy_q <= wx_sel * wy_sel;
    end
    if (cmd.corner_mul) begin
      raw_q   <= rdata;
      wprod_q <= 51'(wxy_q * wz_sel);
    end
    if (cmd.corner_wt) begin
      // An unknown voxel contributes no weight.
      w_q <= raw_q[VAL_W-1] ? '0 : wround[48:24];
    end
    if (cmd.accept_sample) begin
      wsum_q <= '0;
      vsum_q <= '0;
    end else if (cmd.corner_acc) begin
      wsum_q <= wsum_q + 28'(w_q);
      vsum_q <= vsum_q + 60'(w_q * raw_q[VAL_W-2:0]);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [27:0] rem_q;
  logic [31:0] numlo_q, quo_q;
  logic [28:0] rem_try;

  assign num     = vsum_q + 60'(wsum_q[27:1]);
  assign rem_try = {rem_q, numlo_q[31]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_q   <= num[59:32];
      numlo_q <= num[31:0];
      quo_q   <= '0;
    end else if (cmd.div_step) begin
      numlo_q <= {numlo_q[30:0], 1'b0};
      if (rem_try >= {1'b0, wsum_q}) begin
        rem_q <= 28'(rem_try - {1'b0, wsum_q});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_try[27:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign stat.bad           = bad_q;
  assign stat.wsum_zero     = (wsum_q == '0);
  assign stat.corner_active = (wx_sel != '0) && (wy_sel != '0) && (wz_sel != '0);

  assign no_data      = bad_q || (wsum_q == '0);
  assign sample_value = no_data ? NO_DATA_VALUE :
                        ((quo_q > SAT_VALUE) ? SAT_VALUE : quo_q);
  assign slice_end    = last_q;

endmodule
`default_nettype wire
